[rtl/cmux_pkg.sv]
// shared types and constants of the cmux frame receiver
// used by the command queue, front end, back end and top level; no dependencies
package cmux_pkg;

  // default sizing
  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned CHANNELS    = 8;

  // width of a payload length or byte count (frames never exceed 64 bytes)
  localparam int unsigned LEN_W = 7;

  // command queue depth
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  // framing and control field codes
  localparam logic [7:0] FLAG_BYTE = 8'hF9;
  localparam logic [7:0] PF_BIT    = 8'h10;
  localparam logic [7:0] CTRL_SABM = 8'h2F;
  localparam logic [7:0] CTRL_DISC = 8'h43;
  localparam logic [7:0] CTRL_UI   = 8'h03;
  localparam logic [7:0] CTRL_UIH  = 8'hEF;

  // response frame requested
  localparam logic RESP_UA = 1'b0;
  localparam logic RESP_DM = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_RESP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CH_UNKNOWN = 2'd0,
    CH_OPEN    = 2'd1,
    CH_CLOSED  = 2'd2
  } chan_e;

  typedef enum logic [1:0] {
    LINK_INIT   = 2'd0,
    LINK_OPEN   = 2'd1,
    LINK_CLOSED = 2'd2
  } link_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EV0,
    BK_EV1,
    BK_PRD,
    BK_PDAT
  } back_e;

  // one decoded frame, handed from front to back
  typedef struct packed {
    logic [5:0]       ch;
    link_e            link;
    logic [1:0]       ev_cnt;    // event words before the payload, 0..2
    kind_e            ev0_kind;
    logic             ev0_resp;  // second event is always a close
    logic [LEN_W-1:0] pay_len;
    logic             hdr4;      // payload starts at byte 4, else byte 3
    logic             bank;
  } cmd_t;

  // frame bank released by the back end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

[rtl/cmux_frame_store.sv]
// two-bank frame byte store: one write port, one registered read port
// no dependencies
module cmux_frame_store #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/cmux_cmd_fifo.sv]
// short command queue between the frame front end and the result back end
// depends on cmux_pkg
module cmux_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmux_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cmux_pkg::cmd_t data_o
);

  localparam int unsigned CntW = $clog2(cmux_pkg::CMD_DEPTH + 1);

  cmux_pkg::cmd_t                    mem_q [cmux_pkg::CMD_DEPTH];
  logic [cmux_pkg::CMD_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [cmux_pkg::CMD_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(cmux_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/cmux_rx_front.sv]
// front end: frame delineation, header capture, frame decode, channel and link state
// depends on cmux_pkg; writes the frame store, feeds the command queue
module cmux_rx_front #(
  parameter  int unsigned FRAME_BYTES = cmux_pkg::FRAME_BYTES,
  parameter  int unsigned CHANNELS    = cmux_pkg::CHANNELS,
  localparam int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     rx_byte_i,
  output logic           full_o,
  output logic           cmd_push_o,
  output cmux_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i,
  input  cmux_pkg::rel_t rel_i,
  output logic           wr_en_o,
  output logic [AW:0]    wr_addr_o,
  output logic [7:0]     wr_data_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                recv_q, recv_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          ctrl_q, ctrl_d;
  logic [7:0]          len0_q, len0_d;
  logic [7:0]          len1_q, len1_d;
  logic [1:0]          pend_q, pend_d;
  logic                wb_q, wb_d;
  cmux_pkg::link_e     mux_q, mux_d;
  cmux_pkg::chan_e     chan_q [CHANNELS];

  logic                accept;
  logic [CntW-1:0]     cnt_inc;
  logic [7:0]          lo, hi;
  logic [2:0]          hlen;
  logic [14:0]         dlen;
  logic [15:0]         flen;
  logic                hdr_done;

  // decode of the stored frame
  logic [5:0]          ch;
  logic [7:0]          ctrl_type;
  logic                in_range;
  logic [ChW-1:0]      cidx;
  cmux_pkg::chan_e     st;
  logic [14:0]         frame_dlen;
  cmux_pkg::cmd_t      dec_cmd;
  logic                dec_chan_we;
  cmux_pkg::chan_e     dec_chan_val;
  cmux_pkg::link_e     dec_mux;
  logic                dec_any;
  logic                chan_we;

  assign accept  = push_i && !full_o;
  assign full_o  = cmd_full_i || pend_q[wb_q];
  assign cnt_inc = cnt_q + 1'b1;

  // header fields, taking the byte being stored where it is one of them
  always_comb begin
    lo       = (cnt_q == CntW'(2)) ? rx_byte_i : len0_q;
    hi       = (cnt_q == CntW'(3)) ? rx_byte_i : len1_q;
    hlen     = lo[0] ? 3'd3 : 3'd4;
    dlen     = lo[0] ? {8'h00, lo[7:1]} : {hi, lo[7:1]};
    flen     = 16'(hlen) + {1'b0, dlen} + 16'd1;
    hdr_done = (16'(cnt_inc) >= 16'd3) && (16'(cnt_inc) >= 16'(hlen));
  end

  always_comb begin
    ch          = addr_q[7:2];
    ctrl_type   = ctrl_q & ~cmux_pkg::PF_BIT;
    in_range    = ({1'b0, ch} < 7'(CHANNELS));
    cidx        = ch[ChW-1:0];
    st          = chan_q[cidx];
    frame_dlen  = len0_q[0] ? {8'h00, len0_q[7:1]} : {len1_q, len0_q[7:1]};

    dec_chan_we  = 1'b0;
    dec_chan_val = cmux_pkg::CH_OPEN;
    dec_mux      = mux_q;

    dec_cmd          = '0;
    dec_cmd.ch       = ch;
    dec_cmd.ev0_kind = cmux_pkg::KIND_PAYLOAD;
    dec_cmd.ev0_resp = cmux_pkg::RESP_UA;
    dec_cmd.hdr4     = !len0_q[0];
    dec_cmd.bank     = wb_q;

    if (in_range) begin
      case (ctrl_type)
        cmux_pkg::CTRL_SABM: begin
          if (st != cmux_pkg::CH_OPEN) begin
            dec_chan_we    = 1'b1;
            dec_cmd.ev_cnt = 2'd1;
            if (ch != '0) begin
              dec_cmd.ev0_kind = cmux_pkg::KIND_OPEN;
            end else begin
              dec_cmd.ev0_kind = cmux_pkg::KIND_RESP;
              dec_mux          = cmux_pkg::LINK_OPEN;
            end
          end else if (ch != '0) begin
            dec_chan_we      = 1'b1;
            dec_chan_val     = cmux_pkg::CH_CLOSED;
            dec_cmd.ev_cnt   = 2'd1;
            dec_cmd.ev0_kind = cmux_pkg::KIND_CLOSE;
          end
        end
        cmux_pkg::CTRL_DISC: begin
          if (ch == '0) begin
            dec_mux = cmux_pkg::LINK_CLOSED;
          end
          dec_cmd.ev_cnt   = 2'd2;
          dec_cmd.ev0_kind = cmux_pkg::KIND_RESP;
          dec_cmd.ev0_resp = cmux_pkg::RESP_DM;
        end
        cmux_pkg::CTRL_UI, cmux_pkg::CTRL_UIH: begin
          if (st != cmux_pkg::CH_OPEN) begin
            dec_chan_we = 1'b1;
            if (ch != '0) begin
              dec_cmd.ev_cnt   = 2'd1;
              dec_cmd.ev0_kind = cmux_pkg::KIND_OPEN;
            end
          end
          if (ch != '0) begin
            dec_cmd.pay_len = cmux_pkg::LEN_W'(frame_dlen);
          end
        end
        default: begin
        end
      endcase
    end

    dec_cmd.link = dec_mux;
    dec_any      = (dec_cmd.ev_cnt != '0) || (dec_cmd.pay_len != '0);
  end

  always_comb begin
    recv_d     = recv_q;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    ctrl_d     = ctrl_q;
    len0_d     = len0_q;
    len1_d     = len1_q;
    wb_d       = wb_q;
    mux_d      = mux_q;
    pend_d     = pend_q;
    wr_en_o    = 1'b0;
    cmd_push_o = 1'b0;
    chan_we    = 1'b0;

    if (rel_i.valid) begin
      pend_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (recv_q) begin
        if (cnt_q == '0 && rx_byte_i == cmux_pkg::FLAG_BYTE) begin
          // repeated opening flag
        end else if (cnt_q >= CntW'(FRAME_BYTES)) begin
          recv_d = 1'b0;
          cnt_d  = '0;
        end else begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_inc;
          if (cnt_q == CntW'(0)) addr_d = rx_byte_i;
          if (cnt_q == CntW'(1)) ctrl_d = rx_byte_i;
          if (cnt_q == CntW'(2)) len0_d = rx_byte_i;
          if (cnt_q == CntW'(3)) len1_d = rx_byte_i;
          if (hdr_done) begin
            if (flen > 16'(FRAME_BYTES)) begin
              recv_d = 1'b0;
              cnt_d  = '0;
            end else if (16'(cnt_inc) == flen) begin
              recv_d = 1'b0;
            end
          end
        end
      end else if (rx_byte_i == cmux_pkg::FLAG_BYTE) begin
        if (cnt_q == '0) begin
          recv_d = 1'b1;
        end else begin
          // closing flag of a complete frame
          cnt_d      = '0;
          chan_we    = dec_chan_we;
          mux_d      = dec_mux;
          cmd_push_o = dec_any;
          if (dec_cmd.pay_len != '0) begin
            pend_d[wb_q] = 1'b1;
            wb_d         = !wb_q;
          end
        end
      end
    end
  end

  assign cmd_o     = dec_cmd;
  assign wr_addr_o = {wb_q, cnt_q[AW-1:0]};
  assign wr_data_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q <= 1'b0;
      cnt_q  <= '0;
      pend_q <= '0;
      wb_q   <= 1'b0;
      mux_q  <= cmux_pkg::LINK_INIT;
    end else begin
      recv_q <= recv_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      wb_q   <= wb_d;
      mux_q  <= mux_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= cmux_pkg::CH_UNKNOWN;
      end
    end else if (chan_we) begin
      chan_q[cidx] <= dec_chan_val;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    ctrl_q <= ctrl_d;
    len0_q <= len0_d;
    len1_q <= len1_d;
  end

endmodule

[rtl/cmux_rx_back.sv]
// back end: expands queued frame commands into result words, reads payload from the store
// depends on cmux_pkg; reads the frame store, pops the command queue
module cmux_rx_back #(
  parameter  int unsigned FRAME_BYTES = cmux_pkg::FRAME_BYTES,
  localparam int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  cmux_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic [AW:0]    rd_addr_o,
  input  logic [7:0]     rd_data_i,
  output cmux_pkg::rel_t rel_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [1:0]     kind_o,
  output logic [5:0]     channel_o,
  output logic           response_type_o,
  output logic [7:0]     payload_byte_o,
  output logic           last_o,
  output logic [1:0]     link_state_o
);

  cmux_pkg::back_e              state_q, state_d;
  cmux_pkg::cmd_t               cur_q, cur_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [cmux_pkg::LEN_W-1:0]   rem_q, rem_d;

  logic                         out_v_q, out_v_d;
  cmux_pkg::kind_e              out_kind_q, out_kind_d;
  logic [5:0]                   out_ch_q, out_ch_d;
  logic                         out_resp_q, out_resp_d;
  logic [7:0]                   out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;
  cmux_pkg::link_e              out_link_q, out_link_d;

  logic                         slot_free;

  assign slot_free = !out_v_q || pop_i;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    out_v_d    = out_v_q && !pop_i;
    out_kind_d = out_kind_q;
    out_ch_d   = out_ch_q;
    out_resp_d = out_resp_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_link_d = out_link_q;
    cmd_pop_o  = 1'b0;
    rel_o      = '0;

    case (state_q)
      cmux_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          idx_d     = cmd_i.hdr4 ? AW'(4) : AW'(3);
          rem_d     = cmd_i.pay_len;
          state_d   = (cmd_i.ev_cnt != '0) ? cmux_pkg::BK_EV0 : cmux_pkg::BK_PRD;
        end
      end
      cmux_pkg::BK_EV0: begin
        if (slot_free) begin
          out_v_d    = 1'b1;
          out_kind_d = cur_q.ev0_kind;
          out_ch_d   = cur_q.ch;
          out_resp_d = cur_q.ev0_resp;
          out_byte_d = '0;
          out_link_d = cur_q.link;
          out_last_d = (cur_q.ev_cnt == 2'd1) && (rem_q == '0);
          if (cur_q.ev_cnt == 2'd2) begin
            state_d = cmux_pkg::BK_EV1;
          end else if (rem_q != '0) begin
            state_d = cmux_pkg::BK_PRD;
          end else begin
            state_d = cmux_pkg::BK_IDLE;
          end
        end
      end
      cmux_pkg::BK_EV1: begin
        if (slot_free) begin
          out_v_d    = 1'b1;
          out_kind_d = cmux_pkg::KIND_CLOSE;
          out_ch_d   = cur_q.ch;
          out_resp_d = cmux_pkg::RESP_UA;
          out_byte_d = '0;
          out_link_d = cur_q.link;
          out_last_d = (rem_q == '0);
          state_d    = (rem_q != '0) ? cmux_pkg::BK_PRD : cmux_pkg::BK_IDLE;
        end
      end
      cmux_pkg::BK_PRD: begin
        // store read in flight
        state_d = cmux_pkg::BK_PDAT;
      end
      cmux_pkg::BK_PDAT: begin
        if (slot_free) begin
          out_v_d    = 1'b1;
          out_kind_d = cmux_pkg::KIND_PAYLOAD;
          out_ch_d   = cur_q.ch;
          out_resp_d = cmux_pkg::RESP_UA;
          out_byte_d = rd_data_i;
          out_link_d = cur_q.link;
          out_last_d = (rem_q == cmux_pkg::LEN_W'(1));
          rem_d      = rem_q - 1'b1;
          idx_d      = idx_q + 1'b1;
          if (rem_q == cmux_pkg::LEN_W'(1)) begin
            state_d     = cmux_pkg::BK_IDLE;
            rel_o.valid = 1'b1;
            rel_o.bank  = cur_q.bank;
          end else begin
            state_d = cmux_pkg::BK_PRD;
          end
        end
      end
      default: begin
        state_d = cmux_pkg::BK_IDLE;
      end
    endcase
  end

  assign rd_addr_o       = {cur_q.bank, idx_q};
  assign empty_o         = !out_v_q;
  assign kind_o          = out_kind_q;
  assign channel_o       = out_ch_q;
  assign response_type_o = out_resp_q;
  assign payload_byte_o  = out_byte_q;
  assign last_o          = out_last_q;
  assign link_state_o    = out_link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmux_pkg::BK_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    out_kind_q <= out_kind_d;
    out_ch_q   <= out_ch_d;
    out_resp_q <= out_resp_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_link_q <= out_link_d;
  end

  // a payload read is only started with bytes left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmux_pkg::BK_PRD) |-> (rem_q != '0))
    else $error("payload read with no bytes left");

  // payload words never belong to the control channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == cmux_pkg::KIND_PAYLOAD) |-> (out_ch_q != '0))
    else $error("payload word on control channel");

  // back to idle only after the final word of a frame has been loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmux_pkg::BK_IDLE && out_v_q) |-> out_last_q)
    else $error("idle with an unfinished frame in the output register");

endmodule

[rtl/cmux_frame_receiver_core.sv]
// top level of the cmux basic-option frame receiver
// depends on cmux_pkg, cmux_rx_front, cmux_cmd_fifo, cmux_frame_store, cmux_rx_back
//
// Receives link bytes as words on a queue-style input (push/full) and delivers
// result words on a queue-style output (empty/pop). A 0xF9 flag opens a frame;
// address, control, length (one or two bytes, EA in bit 0), payload and FCS
// are stored, and the next flag decodes SABM, DISC, UI and UIH. Results are
// channel open/close events, UA/DM response requests and the payload bytes of
// UI/UIH frames on nonzero channels; last marks the final word of a frame and
// link_state is the link state after that frame. The FCS is not checked;
// channels at or above CHANNELS and unknown control types give no words, and
// frames longer than FRAME_BYTES are dropped. Timing: one input byte is taken
// per cycle while full is low. A closing flag queues a command; the back end
// pops it when idle and emits event words at one per cycle while results are
// popped, then payload bytes one at a time (store read, then output
// register), each read starting once the previous byte is loaded. The store
// has two frame banks: the next frame is received while the previous one is
// read out, and full is raised only while both banks wait for readout or the
// two-entry command queue is full. No clearing pass is needed after reset.
module cmux_frame_receiver_core #(
  parameter int unsigned FRAME_BYTES = cmux_pkg::FRAME_BYTES,  // 8..64
  parameter int unsigned CHANNELS    = cmux_pkg::CHANNELS      // 1..64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [5:0] channel_o,
  output logic       response_type_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o,
  output logic [1:0] link_state_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  // front to queue
  logic           cmd_push;
  logic           cmd_full;
  cmux_pkg::cmd_t cmd_in;
  // queue to back
  logic           cmd_pop;
  logic           cmd_empty;
  cmux_pkg::cmd_t cmd_out;
  // bank release from back to front
  cmux_pkg::rel_t rel;
  // frame store ports
  logic           wr_en;
  logic [AW:0]    wr_addr;
  logic [7:0]     wr_data;
  logic [AW:0]    rd_addr;
  logic [7:0]     rd_data;

  // framing, header capture and decode; owns channel and link state
  cmux_rx_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full),
    .rel_i      (rel),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // decoded frames waiting for readout
  cmux_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  // two frame banks, bank select is the top address bit
  cmux_frame_store #(
    .ADDR_W (AW + 1)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // result sequencing and output register
  cmux_rx_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .rel_o           (rel),
    .empty_o         (empty),
    .pop_i           (pop),
    .kind_o          (kind_o),
    .channel_o       (channel_o),
    .response_type_o (response_type_o),
    .payload_byte_o  (payload_byte_o),
    .last_o          (last_o),
    .link_state_o    (link_state_o)
  );

endmodule
